// ----- hw/rtl/life_automaton_board_step_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the life board step block
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_BOARD_STEP_MACROS_SVH
`define LIFE_AUTOMATON_BOARD_STEP_MACROS_SVH

// Same-cycle implication
`define LIFEB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LIFEB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lifeb_pkg.sv -----
// ----------------------------------------------------------------------------
// Life board package
// Board geometry, field widths, codes and transaction types.
// ----------------------------------------------------------------------------
package lifeb_pkg;

  localparam int unsigned MaxWidth  = 64;
  localparam int unsigned MaxHeight = 64;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);

  localparam int unsigned DimW      = 7;
  localparam int unsigned GenW      = 32;
  localparam int unsigned RowFieldW = 6;
  localparam int unsigned ColFieldW = 6;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned NbrW      = 4;

  // B3/S23 neighbour counts
  localparam logic [NbrW-1:0] BirthCount   = NbrW'(3);
  localparam logic [NbrW-1:0] SurviveCount = NbrW'(2);

  typedef enum logic [1:0] {
    ModeWrite   = 2'd0,
    ModeRead    = 2'd1,
    ModeAdvance = 2'd2
  } lifeb_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgActiveWidth  = CfgIdxW'(0),
    CfgActiveHeight = CfgIdxW'(1)
  } lifeb_cfg_e;

  typedef struct packed {
    logic [1:0]           mode;
    logic [RowFieldW-1:0] row;
    logic [ColFieldW-1:0] col;
    logic                 cell_in;
  } lifeb_in_t;

  typedef struct packed {
    logic            cell_out;
    logic [GenW-1:0] generation;
  } lifeb_out_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } lifeb_cell_ctrl_t;

  typedef struct packed {
    logic above;
    logic centre;
    logic below;
  } lifeb_tap_t;

endpackage

// ----- hw/rtl/lifeb_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lifeb_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/lifeb_cell.sv -----
// ----------------------------------------------------------------------------
// Life board column cell
// Holds a three-row window of one column and works out its next value.
// ----------------------------------------------------------------------------
module lifeb_cell (
  input  logic                       clk_i,
  input  lifeb_pkg::lifeb_cell_ctrl_t ctrl_i,
  input  logic                       below_i,
  input  logic                       active_i,
  input  lifeb_pkg::lifeb_tap_t      left_i,
  input  lifeb_pkg::lifeb_tap_t      right_i,
  output lifeb_pkg::lifeb_tap_t      tap_o,
  output logic                       next_o
);
  import lifeb_pkg::*;

  lifeb_tap_t      win_q;
  logic [NbrW-1:0] nbr_cnt;

  // Shift the window down by one row as each new row arrives
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      win_q <= '0;
    end else if (ctrl_i.shift) begin
      win_q.above  <= win_q.centre;
      win_q.centre <= win_q.below;
      win_q.below  <= below_i;
    end
  end

  // Columns outside the board read as dead to their neighbours
  assign tap_o = active_i ? win_q : '0;

  assign nbr_cnt = NbrW'(left_i.above) + NbrW'(left_i.centre) + NbrW'(left_i.below)
                 + NbrW'(right_i.above) + NbrW'(right_i.centre) + NbrW'(right_i.below)
                 + NbrW'(tap_o.above) + NbrW'(tap_o.below);

  // Inactive columns keep their stored value
  assign next_o = active_i ? ((nbr_cnt == BirthCount) ||
                              ((nbr_cnt == SurviveCount) && win_q.centre))
                           : win_q.centre;

endmodule

// ----- hw/rtl/life_automaton_board_step.sv -----
// ----------------------------------------------------------------------------
// Life board step, rule B3/S23
// Single-bit board in a row memory, advanced by a chain of column cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one transaction per
//   item: write a cell, read a cell or advance the board one generation.
//   Output channel (out_valid_o/out_ready_i/out_data_o) returns exactly one
//   transaction per item: the read cell value (0 otherwise) and the generation.
//   Configuration channel (cfg_valid_i/cfg_ready_o) sets active width and
//   height; it is always ready and should only be used while the block is idle.
// Sequencing:
//   Write and read items inside the region pass through the access and response
//   states; other writes, reads and no-op items go straight to response.
//   Advance: one row per cycle streams through the column cells in the feed
//   state, then drain and response; one item is in flight at a time, so the
//   next item is accepted only once the block is back in idle.
// Reset:
//   Per-row valid bits clear at once, so the board reads as all dead straight
//   away; there is no clearing pass. Generation returns to 1 and both
//   dimensions to 64.
// Stall:
//   A result sits in the output register until taken; the block finishes its
//   current item and holds it until the register frees, then accepts the next.
// ----------------------------------------------------------------------------
`include "life_automaton_board_step_macros.svh"

module life_automaton_board_step (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lifeb_pkg::lifeb_in_t            in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lifeb_pkg::lifeb_out_t           out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lifeb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lifeb_pkg::DimW-1:0]      cfg_data_i
);
  import lifeb_pkg::*;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StAccess = 5'b00010,
    StFeed   = 5'b00100,
    StDrain  = 5'b01000,
    StResp   = 5'b10000
  } lifeb_state_e;

  // Control state
  lifeb_state_e           state_q, state_d;
  logic [RowW:0]          feed_cnt_q, feed_cnt_d;
  logic                   s1_vld_q, s1_vld_d;
  logic                   win_vld_q, win_vld_d;
  logic [MaxHeight-1:0]   row_vld_q, row_vld_d;
  logic [GenW-1:0]        gen_q, gen_d;
  logic                   out_valid_q, out_valid_d;
  logic [DimW-1:0]        width_q, width_d;
  logic [DimW-1:0]        height_q, height_d;

  // Payload
  logic                   s1_zero_q, s1_zero_d;
  logic [RowW:0]          s1_cnt_q, s1_cnt_d;
  logic [RowW-1:0]        win_row_q, win_row_d;
  logic                   cell_bit_q, cell_bit_d;
  logic [RowW-1:0]        acc_row_q, acc_row_d;
  logic [ColW-1:0]        acc_col_q, acc_col_d;
  logic                   acc_val_q, acc_val_d;
  logic                   acc_wr_q, acc_wr_d;
  logic                   rmask_q, rmask_d;
  lifeb_out_t             out_q, out_d;

  logic [DimW-1:0]        eff_w, eff_h;
  logic                   in_fire, in_region, slot_free, feed_real;
  logic [RowW-1:0]        feed_row;
  logic [RowW-1:0]        ram_raddr, ram_waddr;
  logic                   ram_we;
  logic [MaxWidth-1:0]    ram_wdata, ram_rdata, acc_wdata;
  logic [MaxWidth-1:0]    col_act, below_bits, next_row;
  lifeb_cell_ctrl_t       cell_ctrl;
  lifeb_tap_t             taps [MaxWidth];

  // Saturate the dimensions to the board size
  assign eff_w = (width_q  > DimW'(MaxWidth))  ? DimW'(MaxWidth)  : width_q;
  assign eff_h = (height_q > DimW'(MaxHeight)) ? DimW'(MaxHeight) : height_q;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign in_region   = (DimW'(in_data_i.row) < eff_h) && (DimW'(in_data_i.col) < eff_w);
  assign slot_free   = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign feed_row  = feed_cnt_q[RowW-1:0];
  assign feed_real = DimW'(feed_cnt_q) < eff_h;

  // Read the addressed row on acceptance; otherwise stream rows for an advance
  assign ram_raddr = (state_q == StIdle) ? RowW'(in_data_i.row) : feed_row;

  lifeb_ram #(
    .Width (MaxWidth),
    .Depth (MaxHeight)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Clear the window when an advance starts; shift it as each row lands
  assign cell_ctrl.clear = in_fire && (in_data_i.mode == ModeAdvance);
  assign cell_ctrl.shift = s1_vld_q;

  for (genvar j = 0; j < MaxWidth; j++) begin : g_col
    lifeb_tap_t left_tap, right_tap;

    assign col_act[j]    = DimW'(j) < eff_w;
    assign below_bits[j] = ram_rdata[j] && !s1_zero_q;

    // Board edges have dead neighbours beyond them
    if (j == 0) begin : g_left_edge
      assign left_tap = '0;
    end else begin : g_left
      assign left_tap = taps[j-1];
    end
    if (j == MaxWidth - 1) begin : g_right_edge
      assign right_tap = '0;
    end else begin : g_right
      assign right_tap = taps[j+1];
    end

    lifeb_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl),
      .below_i  (below_bits[j]),
      .active_i (col_act[j]),
      .left_i   (left_tap),
      .right_i  (right_tap),
      .tap_o    (taps[j]),
      .next_o   (next_row[j])
    );
  end

  // Merge a single-cell write into the fetched row; never-written rows are dead
  always_comb begin
    acc_wdata            = ram_rdata & {MaxWidth{rmask_q}};
    acc_wdata[acc_col_q] = acc_val_q;
  end

  // Memory write: single-cell write-back, or the finished centre row of the window
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = win_row_q;
    ram_wdata = next_row;
    if ((state_q == StAccess) && acc_wr_q) begin
      ram_we    = 1'b1;
      ram_waddr = acc_row_q;
      ram_wdata = acc_wdata;
    end else if (win_vld_q) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    feed_cnt_d  = feed_cnt_q;
    s1_vld_d    = 1'b0;
    s1_zero_d   = s1_zero_q;
    s1_cnt_d    = s1_cnt_q;
    win_vld_d   = 1'b0;
    win_row_d   = win_row_q;
    row_vld_d   = row_vld_q;
    gen_d       = gen_q;
    cell_bit_d  = cell_bit_q;
    acc_row_d   = acc_row_q;
    acc_col_d   = acc_col_q;
    acc_val_d   = acc_val_q;
    acc_wr_d    = acc_wr_q;
    rmask_d     = rmask_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    width_d     = width_q;
    height_d    = height_q;

    // Configuration transaction; unknown indexes drop
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgActiveWidth:  width_d  = cfg_data_i;
        CfgActiveHeight: height_d = cfg_data_i;
        default: ;
      endcase
    end

    // Any written row becomes valid
    if (ram_we) begin
      row_vld_d[ram_waddr] = 1'b1;
    end

    // Stage one: the row read last cycle is at the memory output and shifts into the cells
    if (s1_vld_q) begin
      win_vld_d = (s1_cnt_q != '0);
      win_row_d = RowW'(s1_cnt_q - 1'b1);
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          acc_row_d  = RowW'(in_data_i.row);
          acc_col_d  = ColW'(in_data_i.col);
          acc_val_d  = in_data_i.cell_in;
          rmask_d    = row_vld_q[RowW'(in_data_i.row)];
          cell_bit_d = 1'b0;
          unique case (in_data_i.mode)
            ModeWrite: begin
              acc_wr_d = 1'b1;
              state_d  = in_region ? StAccess : StResp;
            end
            ModeRead: begin
              acc_wr_d = 1'b0;
              state_d  = in_region ? StAccess : StResp;
            end
            ModeAdvance: begin
              feed_cnt_d = '0;
              state_d    = StFeed;
            end
            default: begin
              state_d = StResp;
            end
          endcase
        end
      end
      StAccess: begin
        if (!acc_wr_q) begin
          cell_bit_d = ram_rdata[acc_col_q] && rmask_q;
        end
        state_d = StResp;
      end
      StFeed: begin
        // Issue one row read per cycle, then one dead row below the board
        s1_vld_d   = 1'b1;
        s1_zero_d  = !feed_real || !row_vld_q[feed_row];
        s1_cnt_d   = feed_cnt_q;
        feed_cnt_d = feed_cnt_q + 1'b1;
        if (DimW'(feed_cnt_q) == eff_h) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        // The last row write goes out in the cycle the pipe empties
        if (!s1_vld_q) begin
          gen_d   = gen_q + 1'b1;
          state_d = StResp;
        end
      end
      StResp: begin
        if (slot_free) begin
          out_d.cell_out   = cell_bit_q;
          out_d.generation = gen_q;
          out_valid_d      = 1'b1;
          state_d          = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      feed_cnt_q  <= '0;
      s1_vld_q    <= 1'b0;
      win_vld_q   <= 1'b0;
      row_vld_q   <= '0;
      gen_q       <= GenW'(1);
      out_valid_q <= 1'b0;
      width_q     <= DimW'(64);
      height_q    <= DimW'(64);
    end else begin
      state_q     <= state_d;
      feed_cnt_q  <= feed_cnt_d;
      s1_vld_q    <= s1_vld_d;
      win_vld_q   <= win_vld_d;
      row_vld_q   <= row_vld_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
      width_q     <= width_d;
      height_q    <= height_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_zero_q  <= s1_zero_d;
    s1_cnt_q   <= s1_cnt_d;
    win_row_q  <= win_row_d;
    cell_bit_q <= cell_bit_d;
    acc_row_q  <= acc_row_d;
    acc_col_q  <= acc_col_d;
    acc_val_q  <= acc_val_d;
    acc_wr_q   <= acc_wr_d;
    rmask_q    <= rmask_d;
    out_q      <= out_d;
  end

  `LIFEB_ASSERT_IMPL(a_no_idle_write, ram_we, state_q != StIdle && state_q != StResp, "board written outside an item")
  `LIFEB_ASSERT_IMPL(a_gen_step, gen_q != $past(gen_q), gen_q == $past(gen_q) + 32'd1, "generation jumped")
  `LIFEB_ASSERT_NEXT(a_resp_loads, state_q == StResp && slot_free, out_valid_q && state_q == StIdle, "result not loaded")
  `LIFEB_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready_o, "accepted item left block idle")

endmodule
